@@ sv/sorted_priority_queue_defines.svh @@
// Assertion macros used by the sorted priority queue top level.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Checked on every clock edge once reset is released.
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, including while reset is asserted.
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/spq_pkg.sv @@
// Types and constants shared by the sorted priority queue modules.
`default_nettype none

package spq_pkg;

  // Number of cells in the chain, one entry each.
  localparam int QUEUE_DEPTH = 16;
  // Width of the entry counter, able to hold QUEUE_DEPTH itself.
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int PRIO_W = 8;
  localparam int DATA_W = 8;
  localparam int OCC_W = 5;

  // Request opcodes.
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // One queued entry.
  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [DATA_W-1:0] data;
  } entry_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t item;
  } cmd_t;

endpackage

`default_nettype wire

@@ sv/spq_cell.sv @@
// One compare-and-shift cell of the sorted chain.
`default_nettype none

module spq_cell (
  input  wire logic          clk,
  input  wire spq_pkg::cmd_t cmd,
  input  wire logic          occ,
  input  wire spq_pkg::entry_t left_entry,
  input  wire logic          left_disp,
  input  wire spq_pkg::entry_t right_entry,
  output spq_pkg::entry_t    entry,
  output logic               disp
);
  import spq_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  // The cell is displaced when it is empty or holds a strictly lower priority,
  // so equal priorities stay ahead of the new entry.
  assign disp = !occ || (entry_r.prio < cmd.item.prio);

  // Insert: the first displaced cell takes the new entry, the ones after it
  // take their left neighbor. Remove: every cell takes its right neighbor.
  always_comb begin
    entry_nxt = entry_r;
    if (cmd.enq && disp) begin
      entry_nxt = left_disp ? left_entry : cmd.item;
    end else if (cmd.deq) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

`default_nettype wire

@@ sv/sorted_priority_queue.sv @@
// Top level of the sorted priority queue built as a chain of shift cells.
//
//  channel | ports                                        | direction
//  --------+----------------------------------------------+----------
//  in      | in_valid, in_ready, in_op, in_item_prio,     | request in
//          | in_item_data                                 |
//  out     | out_valid, out_ready, out_status, out_prio,  | result out
//          | out_data, out_occupancy, out_is_empty,       |
//          | out_is_full                                  |
//
// For each request, every cell compares against the new priority and shifts
// in parallel, and the result is registered in the output register.
// A new request is taken while the previous result is being taken, so
// the block sustains one request per cycle when out_ready stays high.
// Synchronous active-low reset empties the queue; cell contents are not reset.
// When the output register is full and out_ready is low, in_ready drops.
`default_nettype none
`include "sorted_priority_queue_defines.svh"

module sorted_priority_queue (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_op,
  input  wire logic [spq_pkg::PRIO_W-1:0]  in_item_prio,
  input  wire logic [spq_pkg::DATA_W-1:0]  in_item_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [1:0]                       out_status,
  output logic [spq_pkg::PRIO_W-1:0]       out_prio,
  output logic [spq_pkg::DATA_W-1:0]       out_data,
  output logic [spq_pkg::OCC_W-1:0]        out_occupancy,
  output logic                             out_is_empty,
  output logic                             out_is_full
);
  import spq_pkg::*;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

  logic             in_fire;
  logic             is_full_now;
  logic             is_empty_now;
  cmd_t             cmd;
  entry_t           cell_entry [QUEUE_DEPTH];
  logic             cell_disp  [QUEUE_DEPTH];

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  status_t          status_r, status_nxt;
  entry_t           head_r, head_nxt;

  assign in_ready     = !out_valid_r || out_ready;
  assign in_fire      = in_valid && in_ready;
  assign is_full_now  = (count_r == FULL_CNT);
  assign is_empty_now = (count_r == '0);

  // Command to the chain; requests that fail leave the cells untouched.
  always_comb begin
    cmd.enq       = in_fire && (in_op == OP_ENQ) && !is_full_now;
    cmd.deq       = in_fire && (in_op == OP_DEQ) && !is_empty_now;
    cmd.item.prio = in_item_prio;
    cmd.item.data = in_item_data;
  end

  // Chain of cells: cell 0 holds the head, occupied cells form a prefix.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    logic   occ;
    entry_t left_entry;
    logic   left_disp;
    entry_t right_entry;

    assign occ = (IDX < count_r);

    if (i == 0) begin : g_first
      assign left_entry = cmd.item;
      assign left_disp  = 1'b0;
    end else begin : g_mid
      assign left_entry = cell_entry[i-1];
      assign left_disp  = cell_disp[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_entry = cell_entry[i];
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occ         (occ),
      .left_entry  (left_entry),
      .left_disp   (left_disp),
      .right_entry (right_entry),
      .entry       (cell_entry[i]),
      .disp        (cell_disp[i])
    );
  end

  // Next count, status and result fields for the accepted request.
  always_comb begin
    count_nxt     = count_r;
    status_nxt    = status_r;
    head_nxt      = head_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
      status_nxt    = ST_OK;
      head_nxt      = '0;
      if (in_op == OP_ENQ) begin
        if (is_full_now) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + ONE_CNT;
        end
      end else begin
        if (is_empty_now) begin
          status_nxt = ST_EMPTY;
        end else begin
          head_nxt  = cell_entry[0];
          count_nxt = count_r - ONE_CNT;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    status_r <= status_nxt;
    head_r   <= head_nxt;
  end

  // Occupancy flags follow the held count, which only moves with a result.
  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_prio      = head_r.prio;
  assign out_data      = head_r.data;
  assign out_occupancy = OCC_W'(count_r);
  assign out_is_empty  = (count_r == '0);
  assign out_is_full   = (count_r == FULL_CNT);

  // Checks on the count and the ordering held in the chain.
  `SPQ_ASSERT(a_count_bound, count_r <= FULL_CNT, "entry count exceeds depth")
  `SPQ_ASSERT(a_head_sorted,
              (count_r >= CNT_W'(2)) |-> (cell_entry[0].prio >= cell_entry[1].prio),
              "head is not the highest priority")
  `SPQ_ASSERT(a_full_flag,
              (out_valid_r && (status_r == ST_FULL)) |-> out_is_full,
              "full status while queue not full")
  `SPQ_ASSERT(a_deq_count,
              (in_fire && (in_op == OP_DEQ) && !is_empty_now) |=>
                (count_r == $past(count_r) - ONE_CNT),
              "dequeue did not lower the count")
  `SPQ_ASSERT_ALWAYS(a_reset_empty,
                     !rst_n |=> (count_r == '0) && !out_valid_r,
                     "reset did not empty the queue")

endmodule

`default_nettype wire
